[rtl/nsv_pkg.sv]
// nsv_pkg: shared types, constants and character classes for the
// nucleotide sequence validator; no dependencies
package nsv_pkg;

  localparam int COUNT_BITS_DEF = 32;
  localparam int CFG_DATA_W     = 32;
  localparam int CFG_INDEX_W    = 3;
  localparam logic [31:0] LARGE_LIMIT = 32'd1000000;
  localparam logic [1:0]  PATTERN_MIN = 2'd2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_AUTO_UPPERCASE   = 3'd0,
    CFG_ALLOW_WHITESPACE = 3'd1,
    CFG_ALLOW_AMBIGUOUS  = 3'd2,
    CFG_MIN_LENGTH       = 3'd3,
    CFG_MAX_LENGTH       = 3'd4
  } cfg_index_t;

  typedef enum logic [1:0] {
    FATAL_NONE          = 2'd0,
    FATAL_EMPTY         = 2'd1,
    FATAL_SHORT_PATTERN = 2'd2,
    FATAL_LOWERCASE     = 2'd3
  } fatal_t;

  typedef struct packed {
    logic        auto_uppercase;
    logic        allow_whitespace;
    logic        allow_ambiguous;
    logic [31:0] min_length;
    logic [31:0] max_length;
  } cfg_t;

  // one classified byte as handed from front to back
  typedef struct packed {
    logic kind;
    logic has_char;
    logic keep;
    logic ambig;
    logic bad;
    logic lower;
    logic last;
  } item_t;

  typedef struct packed {
    logic        is_valid;
    fatal_t      fatal_code;
    logic        too_short;
    logic        too_long;
    logic        invalid_seen;
    logic [31:0] invalid_count;
    logic [31:0] ambiguous_count;
    logic [31:0] cleaned_length;
    logic        ambiguity_warning;
    logic        large_warning;
  } res_t;

  function automatic logic is_nucleotide(input logic [7:0] c);
    is_nucleotide = (c == "A") || (c == "C") || (c == "G") || (c == "T") || (c == "U");
  endfunction

  function automatic logic is_ambiguity(input logic [7:0] c);
    is_ambiguity = (c == "R") || (c == "Y") || (c == "S") || (c == "W") ||
                   (c == "K") || (c == "M") || (c == "B") || (c == "D") ||
                   (c == "H") || (c == "V") || (c == "N");
  endfunction

endpackage

[rtl/nsv_in_if.sv]
// nsv_in_if: request channel carrying one raw byte per transfer
// no dependencies
interface nsv_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic       has_char;
  logic [7:0] char_byte;
  logic       last;

  modport source(output valid, kind, has_char, char_byte, last, input ready);
  modport sink(input valid, kind, has_char, char_byte, last, output ready);
endinterface

[rtl/nsv_out_if.sv]
// nsv_out_if: result channel, one request per checked string
// no dependencies
interface nsv_out_if;
  logic        valid;
  logic        ready;
  logic        is_valid;
  logic [1:0]  fatal_code;
  logic        too_short;
  logic        too_long;
  logic        invalid_seen;
  logic [31:0] invalid_count;
  logic [31:0] ambiguous_count;
  logic [31:0] cleaned_length;
  logic        ambiguity_warning;
  logic        large_warning;

  modport source(output valid, is_valid, fatal_code, too_short, too_long, invalid_seen,
                 invalid_count, ambiguous_count, cleaned_length, ambiguity_warning,
                 large_warning, input ready);
  modport sink(input valid, is_valid, fatal_code, too_short, too_long, invalid_seen,
               invalid_count, ambiguous_count, cleaned_length, ambiguity_warning,
               large_warning, output ready);
endinterface

[rtl/nsv_front.sv]
// nsv_front: accepts raw bytes and classifies them (whitespace, case, class)
// depends on nsv_pkg and nsv_in_if
module nsv_front
  import nsv_pkg::*;
(
  nsv_in_if.sink in_ch,
  input  cfg_t   cfg,
  input  logic   q_full,
  output logic   q_push,
  output item_t  q_item
);

  logic       lower;
  logic       ws;
  logic [7:0] uc;
  logic       nuc;
  logic       amb;

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  always_comb begin
    lower = in_ch.has_char && (in_ch.char_byte >= "a") && (in_ch.char_byte <= "z");
    ws    = cfg.allow_whitespace &&
            ((in_ch.char_byte == 8'h20) ||
             ((in_ch.char_byte >= 8'h09) && (in_ch.char_byte <= 8'h0D)));
    uc    = (cfg.auto_uppercase && lower) ? (in_ch.char_byte - 8'h20) : in_ch.char_byte;
    nuc   = is_nucleotide(uc);
    amb   = is_ambiguity(uc);

    q_item.kind     = in_ch.kind;
    q_item.has_char = in_ch.has_char;
    q_item.keep     = in_ch.has_char && !ws;
    q_item.ambig    = in_ch.has_char && !ws && !nuc && amb;
    q_item.bad      = in_ch.has_char && !ws && !nuc && !amb;
    q_item.lower    = lower;
    q_item.last     = in_ch.last;
  end

endmodule

[rtl/nsv_fifo.sv]
// nsv_fifo: short queue of classified items between front and back
// depends on nsv_pkg
module nsv_fifo
  import nsv_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t wr_item,
  output logic  full,
  input  logic  pop,
  output item_t rd_item,
  output logic  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t          mem [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign rd_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[rtl/nsv_back.sv]
// nsv_back: per-string counters and the result register
// depends on nsv_pkg and nsv_out_if
module nsv_back
  import nsv_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic   clk,
  input  logic   rst,
  input  cfg_t   cfg,
  input  logic   q_empty,
  input  item_t  q_item,
  output logic   q_pop,
  nsv_out_if.source out_ch
);

  localparam int OW = (COUNT_BITS > 32) ? COUNT_BITS : 32;

  logic                  mid_string;
  logic                  mode_latched;
  logic [1:0]            raw_count;
  logic [COUNT_BITS-1:0] kept_count;
  logic [COUNT_BITS-1:0] bad_count;
  logic [COUNT_BITS-1:0] ambig_count;
  logic                  lower_seen;
  logic                  out_valid;
  res_t                  res;

  logic                  mode_next;
  logic [1:0]            raw_next;
  logic [COUNT_BITS-1:0] kept_next;
  logic [COUNT_BITS-1:0] bad_next;
  logic [COUNT_BITS-1:0] ambig_next;
  logic                  lower_next;
  logic                  out_valid_next;
  res_t                  res_next;
  logic [OW-1:0]         kept_ext;
  logic                  short_f;
  logic                  long_f;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    sat_inc = (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic logic [31:0] clip32(input logic [COUNT_BITS-1:0] v);
    logic [OW-1:0] x;
    x = OW'(v);
    clip32 = (x > OW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : x[31:0];
  endfunction

  assign q_pop = !q_empty && (!q_item.last || !out_valid || out_ch.ready);

  always_comb begin
    mode_next  = mid_string ? mode_latched : q_item.kind;
    raw_next   = (q_item.has_char && (raw_count < PATTERN_MIN)) ? raw_count + 1'b1 : raw_count;
    kept_next  = q_item.keep  ? sat_inc(kept_count)  : kept_count;
    bad_next   = q_item.bad   ? sat_inc(bad_count)   : bad_count;
    ambig_next = q_item.ambig ? sat_inc(ambig_count) : ambig_count;
    lower_next = lower_seen || q_item.lower;

    kept_ext = OW'(kept_next);
    short_f  = !mode_next && (kept_ext < OW'(cfg.min_length));
    long_f   = !mode_next && (cfg.max_length != '0) && (kept_ext > OW'(cfg.max_length));

    res_next = '0;
    if (raw_next == 2'd0) begin
      res_next.fatal_code = FATAL_EMPTY;
    end else if (mode_next && (raw_next < PATTERN_MIN)) begin
      res_next.fatal_code = FATAL_SHORT_PATTERN;
    end else if (lower_next && !cfg.auto_uppercase) begin
      res_next.fatal_code = FATAL_LOWERCASE;
    end else begin
      res_next.fatal_code        = FATAL_NONE;
      res_next.is_valid          = !(short_f || long_f || (bad_next != '0) ||
                                     ((ambig_next != '0) && !cfg.allow_ambiguous));
      res_next.too_short         = short_f;
      res_next.too_long          = long_f;
      res_next.invalid_seen      = (bad_next != '0);
      res_next.invalid_count     = clip32(bad_next);
      res_next.ambiguous_count   = clip32(ambig_next);
      res_next.cleaned_length    = clip32(kept_next);
      res_next.ambiguity_warning = cfg.allow_ambiguous && (ambig_next != '0);
      res_next.large_warning     = kept_ext > OW'(LARGE_LIMIT);
    end

    if (q_pop && q_item.last) begin
      out_valid_next = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_string   <= 1'b0;
      mode_latched <= 1'b0;
      raw_count    <= '0;
      kept_count   <= '0;
      bad_count    <= '0;
      ambig_count  <= '0;
      lower_seen   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      if (q_pop) begin
        if (q_item.last) begin
          mid_string   <= 1'b0;
          mode_latched <= 1'b0;
          raw_count    <= '0;
          kept_count   <= '0;
          bad_count    <= '0;
          ambig_count  <= '0;
          lower_seen   <= 1'b0;
        end else begin
          mid_string   <= 1'b1;
          mode_latched <= mode_next;
          raw_count    <= raw_next;
          kept_count   <= kept_next;
          bad_count    <= bad_next;
          ambig_count  <= ambig_next;
          lower_seen   <= lower_next;
        end
      end
    end
  end

  // result payload, loaded only when a string closes
  always_ff @(posedge clk) begin
    if (q_pop && q_item.last) begin
      res <= res_next;
    end
  end

  assign out_ch.valid             = out_valid;
  assign out_ch.is_valid          = res.is_valid;
  assign out_ch.fatal_code        = res.fatal_code;
  assign out_ch.too_short         = res.too_short;
  assign out_ch.too_long          = res.too_long;
  assign out_ch.invalid_seen      = res.invalid_seen;
  assign out_ch.invalid_count     = res.invalid_count;
  assign out_ch.ambiguous_count   = res.ambiguous_count;
  assign out_ch.cleaned_length    = res.cleaned_length;
  assign out_ch.ambiguity_warning = res.ambiguity_warning;
  assign out_ch.large_warning     = res.large_warning;

endmodule

[rtl/nucleotide_sequence_validator_top.sv]
// nucleotide_sequence_validator_top: top level, configuration registers and
// the front / queue / back chain; depends on nsv_pkg, nsv_in_if, nsv_out_if,
// nsv_front, nsv_fifo and nsv_back
//
// checks a DNA/RNA sequence or a search pattern streamed one byte per request
// on in_ch; kind is taken from the first request of a string and last closes
// it, producing exactly one result request on out_ch. a request with has_char
// low carries no byte. throughput is one byte per clock: in_ch.ready stays high
// as long as the two-entry queue between the classifier and the counter stage
// has room, and a result waiting on out_ch only holds the back end when the
// next string also closes. the closing byte passes the queue entry and then
// the result register before out_ch.valid rises. counters are COUNT_BITS wide
// and saturate; reported counts clip at 32 bits. configuration is written
// through cfg_we / cfg_index / cfg_data and must only change between strings
// once all results are out.
module nucleotide_sequence_validator_top
  import nsv_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  nsv_in_if.sink                 in_ch,
  nsv_out_if.source              out_ch,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t  cfg;
  logic  q_push;
  item_t q_wr_item;
  logic  q_full;
  logic  q_pop;
  item_t q_rd_item;
  logic  q_empty;

  // configuration registers, reset to their documented defaults
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.auto_uppercase   <= 1'b0;
      cfg.allow_whitespace <= 1'b1;
      cfg.allow_ambiguous  <= 1'b1;
      cfg.min_length       <= 32'd1;
      cfg.max_length       <= 32'd0;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_AUTO_UPPERCASE:   cfg.auto_uppercase   <= cfg_data[0];
        CFG_ALLOW_WHITESPACE: cfg.allow_whitespace <= cfg_data[0];
        CFG_ALLOW_AMBIGUOUS:  cfg.allow_ambiguous  <= cfg_data[0];
        CFG_MIN_LENGTH:       cfg.min_length       <= cfg_data[31:0];
        CFG_MAX_LENGTH:       cfg.max_length       <= cfg_data[31:0];
        default:              cfg.auto_uppercase   <= cfg.auto_uppercase;
      endcase
    end
  end

  // front: accept and classify each byte
  nsv_front u_front (
    .in_ch  (in_ch),
    .cfg    (cfg),
    .q_full (q_full),
    .q_push (q_push),
    .q_item (q_wr_item)
  );

  // decoupling queue
  nsv_fifo #(
    .DEPTH (2)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_item (q_wr_item),
    .full    (q_full),
    .pop     (q_pop),
    .rd_item (q_rd_item),
    .empty   (q_empty)
  );

  // back: accumulate per string and register the result
  nsv_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_empty (q_empty),
    .q_item  (q_rd_item),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

[rtl/nsv_checker.sv]
// nsv_checker: port-level assertions on the result channel, bound to the top
// depends on nsv_pkg and nucleotide_sequence_validator_top
module nsv_checker
  import nsv_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        is_valid,
  input logic [1:0]  fatal_code,
  input logic        too_short,
  input logic        too_long,
  input logic        invalid_seen,
  input logic [31:0] invalid_count,
  input logic [31:0] ambiguous_count,
  input logic [31:0] cleaned_length,
  input logic        ambiguity_warning
);

  // stalled result stays valid and keeps its fatal code, validity flag and length
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(fatal_code) && $stable(is_valid) &&
                                $stable(cleaned_length))
    else $error("result changed while stalled");

  // a fatal result carries nothing else
  a_fatal_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && (fatal_code != FATAL_NONE) |->
      !is_valid && !too_short && !too_long && !invalid_seen && !ambiguity_warning &&
      (invalid_count == '0) && (ambiguous_count == '0) && (cleaned_length == '0))
    else $error("fatal result with nonzero fields");

  a_valid_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_valid |-> !invalid_seen && !too_short && !too_long &&
                              (fatal_code == FATAL_NONE))
    else $error("valid result with an error flag");

  a_invalid_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> invalid_seen == (invalid_count != '0))
    else $error("invalid flag disagrees with count");

  a_ambig_warn: assert property (@(posedge clk) disable iff (rst)
    out_valid && ambiguity_warning |-> ambiguous_count != '0)
    else $error("ambiguity warning without ambiguity codes");

endmodule

bind nucleotide_sequence_validator_top nsv_checker u_nsv_checker (
  .clk               (clk),
  .rst               (rst),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .is_valid          (out_ch.is_valid),
  .fatal_code        (out_ch.fatal_code),
  .too_short         (out_ch.too_short),
  .too_long          (out_ch.too_long),
  .invalid_seen      (out_ch.invalid_seen),
  .invalid_count     (out_ch.invalid_count),
  .ambiguous_count   (out_ch.ambiguous_count),
  .cleaned_length    (out_ch.cleaned_length),
  .ambiguity_warning (out_ch.ambiguity_warning)
);
